// ===== hw/rtl/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the base64 character map for the encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  // register indexes on the configuration port
  localparam logic CFG_IDX_WRAP_ENABLE = 1'b0;
  localparam logic CFG_IDX_LINE_LENGTH = 1'b1;

  localparam logic [7:0] LINE_LENGTH_RESET = 8'd76;
  localparam logic [7:0] NEWLINE_CHAR      = 8'h0A;
  localparam logic [7:0] PAD_CHAR          = 8'h3D;
  localparam logic [8:0] COUNT_MAX         = 9'd511;
  localparam logic [8:0] GROUP_CHARS       = 9'd4;

  // most characters one byte can produce
  localparam int MAX_CHARS = 5;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);

  // queue between front and back
  localparam int DESC_DEPTH = 4;
  localparam int PTR_W      = $clog2(DESC_DEPTH);
  localparam int FILL_W     = $clog2(DESC_DEPTH + 1);

  typedef struct packed {
    logic       wrap_en;
    logic [7:0] line_len;
  } cfg_t;

  // characters caused by one input byte, slot 0 goes out first
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CNT_W-1:0]          cnt;
  } desc_t;

  // 6-bit value to its base64 character
  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'(8'h41 + {2'b00, v});
    end else if (v < 6'd52) begin
      r = 8'(8'h61 + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      r = 8'(8'h30 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// takes one byte per cycle while take is high, tracks group phase and line count, and builds
// the list of characters that the byte causes
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic            clk,
  input  logic            rst_n,
  input  b64e_pkg::cfg_t  cfg,
  input  logic [7:0]      in_data_byte,
  input  logic            in_final_byte,
  input  logic            take,
  output b64e_pkg::desc_t desc
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  carry_r, carry_nxt;
  logic [8:0]  lcount_r, lcount_nxt;

  logic [b64e_pkg::CNT_W-1:0] n_base;
  logic [8:0]                 lc_sat;
  logic [8:0]                 lc_grp;
  logic                       grp_done;
  logic                       mid_nl;
  logic                       end_nl;

  // saturating count after one more complete group
  assign lc_sat = (lcount_r >= (b64e_pkg::COUNT_MAX - b64e_pkg::GROUP_CHARS)) ?
                  b64e_pkg::COUNT_MAX : 9'(lcount_r + b64e_pkg::GROUP_CHARS);

  // character list and next state
  always_comb begin
    desc.chars = '0;
    n_base     = '0;
    grp_done   = 1'b0;
    mid_nl     = 1'b0;
    phase_nxt  = phase_r;
    carry_nxt  = carry_r;
    unique case (phase_r)
      PH_SECOND: begin
        desc.chars[0] = b64e_pkg::b64_char({carry_r[1:0], in_data_byte[7:4]});
        carry_nxt     = in_data_byte[3:0];
        phase_nxt     = PH_THIRD;
        n_base        = b64e_pkg::CNT_W'(1);
        if (in_final_byte) begin
          desc.chars[1] = b64e_pkg::b64_char({in_data_byte[3:0], 2'b00});
          desc.chars[2] = b64e_pkg::PAD_CHAR;
          n_base        = b64e_pkg::CNT_W'(3);
          grp_done      = 1'b1;
        end
      end
      PH_THIRD: begin
        desc.chars[0] = b64e_pkg::b64_char({carry_r, in_data_byte[7:6]});
        desc.chars[1] = b64e_pkg::b64_char(in_data_byte[5:0]);
        carry_nxt     = 4'd0;
        phase_nxt     = PH_FIRST;
        grp_done      = 1'b1;
        n_base        = b64e_pkg::CNT_W'(2);
        // mid-line newline after a full group
        if (cfg.wrap_en && (lc_sat >= {1'b0, cfg.line_len})) begin
          desc.chars[2] = b64e_pkg::NEWLINE_CHAR;
          n_base        = b64e_pkg::CNT_W'(3);
          mid_nl        = 1'b1;
        end
      end
      default: begin
        // first byte of a group, the unused phase code behaves the same
        desc.chars[0] = b64e_pkg::b64_char(in_data_byte[7:2]);
        carry_nxt     = {2'b00, in_data_byte[1:0]};
        phase_nxt     = PH_SECOND;
        n_base        = b64e_pkg::CNT_W'(1);
        if (in_final_byte) begin
          desc.chars[1] = b64e_pkg::b64_char({in_data_byte[1:0], 4'b0000});
          desc.chars[2] = b64e_pkg::PAD_CHAR;
          desc.chars[3] = b64e_pkg::PAD_CHAR;
          n_base        = b64e_pkg::CNT_W'(4);
          grp_done      = 1'b1;
        end
      end
    endcase

    lc_grp     = grp_done ? lc_sat : lcount_r;
    if (mid_nl) begin
      lc_grp = 9'd0;
    end
    lcount_nxt = lc_grp;

    // message-end newline goes into the next free slot
    end_nl   = in_final_byte && cfg.wrap_en && (lc_grp != 9'd0);
    desc.cnt = end_nl ? b64e_pkg::CNT_W'(n_base + 1'b1) : n_base;
    for (int i = 0; i < b64e_pkg::MAX_CHARS; i++) begin
      if (end_nl && (n_base == b64e_pkg::CNT_W'(i))) begin
        desc.chars[i] = b64e_pkg::NEWLINE_CHAR;
      end
    end

    if (in_final_byte) begin
      phase_nxt  = PH_FIRST;
      carry_nxt  = 4'd0;
      lcount_nxt = 9'd0;
    end
  end

  // encoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      carry_r  <= 4'd0;
      lcount_r <= 9'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      carry_r  <= carry_nxt;
      lcount_r <= lcount_nxt;
    end
  end

endmodule

// ===== hw/rtl/b64e_fifo.sv =====
// ----------------------------------------------------------------------------
// b64e_fifo
// short queue of character lists between front and back
// ----------------------------------------------------------------------------
module b64e_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  b64e_pkg::desc_t wr_data,
  input  logic            rd_en,
  output b64e_pkg::desc_t rd_data,
  output logic            full,
  output logic            not_empty
);

  b64e_pkg::desc_t mem_r [b64e_pkg::DESC_DEPTH];

  logic [b64e_pkg::PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [b64e_pkg::PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [b64e_pkg::FILL_W-1:0] fill_r, fill_nxt;

  assign full      = (fill_r == b64e_pkg::FILL_W'(b64e_pkg::DESC_DEPTH));
  assign not_empty = (fill_r != '0);
  assign rd_data   = mem_r[rptr_r];

  // pointer and fill updates
  always_comb begin
    wptr_nxt = wr_en ? b64e_pkg::PTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = rd_en ? b64e_pkg::PTR_W'(rptr_r + 1'b1) : rptr_r;
    fill_nxt = fill_r;
    if (wr_en && !rd_en) begin
      fill_nxt = b64e_pkg::FILL_W'(fill_r + 1'b1);
    end else if (!wr_en && rd_en) begin
      fill_nxt = b64e_pkg::FILL_W'(fill_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= b64e_pkg::FILL_W'(b64e_pkg::DESC_DEPTH))
    else $error("queue fill beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> not_empty)
    else $error("queue read while empty");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> (fill_r == b64e_pkg::FILL_W'($past(fill_r) + 1'b1)))
    else $error("queue fill did not grow on write");
`endif

endmodule

// ===== hw/rtl/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// holds one character list and sends its characters one per transfer
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic            clk,
  input  logic            rst_n,
  input  b64e_pkg::desc_t q_data,
  input  logic            q_not_empty,
  output logic            q_rd,
  output logic [7:0]      out_char,
  output logic            out_run_last,
  output logic            empty,
  input  logic            pop
);

  b64e_pkg::desc_t            hold_r;
  logic [b64e_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                       valid_r, valid_nxt;
  logic                       is_last;
  logic                       xfer;

  assign is_last      = (idx_r == b64e_pkg::CNT_W'(hold_r.cnt - 1'b1));
  assign xfer         = pop && valid_r;
  assign q_rd         = q_not_empty && (!valid_r || (xfer && is_last));
  assign empty        = !valid_r;
  assign out_run_last = is_last;

  // pick the current character
  always_comb begin
    out_char = hold_r.chars[0];
    for (int i = 1; i < b64e_pkg::MAX_CHARS; i++) begin
      if (idx_r == b64e_pkg::CNT_W'(i)) begin
        out_char = hold_r.chars[i];
      end
    end
  end

  // advance or reload
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (q_rd) begin
      idx_nxt   = '0;
      valid_nxt = 1'b1;
    end else if (xfer) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = b64e_pkg::CNT_W'(idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      hold_r <= q_data;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r < hold_r.cnt))
    else $error("character index past list end");

  a_cnt_sane: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((hold_r.cnt != '0) &&
                 (hold_r.cnt <= b64e_pkg::CNT_W'(b64e_pkg::MAX_CHARS))))
    else $error("held list has bad length");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !is_last) |=>
      (valid_r && (idx_r == b64e_pkg::CNT_W'($past(idx_r) + 1'b1))))
    else $error("index did not advance within a list");
`endif

endmodule

// ===== hw/rtl/base64_encoder_line_wrap.sv =====
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// streaming base64 encoder with '=' padding and optional line wrapping
// ----------------------------------------------------------------------------
// channel  direction  handshake       payload
// input    in         push / full     in_data_byte[7:0], in_final_byte
// result   out        pop / empty     out_char[7:0], out_run_last
// config   in         cfg_we          cfg_index, cfg_data[7:0]
//
// a byte is taken in any cycle push is high and the four-entry queue is
// not full; it becomes one to five characters, sent one per cycle while
// pop is high, so the output port sets the sustained rate.
// a taken byte goes into the queue, then the held list, then the outputs.
// synchronous active-low reset clears state; no clearing pass is needed.
// either side may stall independently: the queue and held list decouple them.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       empty,
  input  logic       pop
);

  b64e_pkg::cfg_t  cfg_r;
  b64e_pkg::desc_t front_desc;
  b64e_pkg::desc_t q_data;
  logic            take;
  logic            q_rd;
  logic            q_not_empty;

  assign take = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wrap_en  <= 1'b0;
      cfg_r.line_len <= b64e_pkg::LINE_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        b64e_pkg::CFG_IDX_WRAP_ENABLE: cfg_r.wrap_en  <= cfg_data[0];
        b64e_pkg::CFG_IDX_LINE_LENGTH: cfg_r.line_len <= cfg_data;
      endcase
    end
  end

  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .take          (take),
    .desc          (front_desc)
  );

  b64e_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (take),
    .wr_data   (front_desc),
    .rd_en     (q_rd),
    .rd_data   (q_data),
    .full      (full),
    .not_empty (q_not_empty)
  );

  b64e_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_data       (q_data),
    .q_not_empty  (q_not_empty),
    .q_rd         (q_rd),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .empty        (empty),
    .pop          (pop)
  );

endmodule
